[rtl/dtc_pkg.sv]
`timescale 1ns / 1ps
package dtc_pkg;

   localparam int DEF_MAX_DEPTH    = 10;
   localparam int DEF_NUM_FEATURES = 64;
   localparam int NUM_CLASSES      = 256;
   localparam int VALUE_WIDTH      = 32;
   localparam int SLOT_WIDTH       = 10;
   localparam int KIND_WIDTH       = 2;
   localparam int FEATURE_WIDTH    = 6;
   localparam int LABEL_WIDTH      = 8;
   localparam int DEPTH_WIDTH      = 4;
   localparam int CMD_DEPTH        = 4;

   localparam logic [DEPTH_WIDTH-1:0] TREE_DEPTH_RESET = 4'd10;

   typedef enum logic [1:0] {
      OP_NODE     = 2'd0,
      OP_LEAF     = 2'd1,
      OP_FEATURE  = 2'd2,
      OP_CLASSIFY = 2'd3
   } op_type;

   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_UNTRAINED = 2'd1;

   typedef struct packed {
      logic [1:0]                    op;
      logic [SLOT_WIDTH-1:0]         slot_index;
      logic [KIND_WIDTH-1:0]         node_kind;
      logic [FEATURE_WIDTH-1:0]      split_feature;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [LABEL_WIDTH-1:0]        leaf_label;
   } req_payload_type;

   typedef struct packed {
      logic [LABEL_WIDTH-1:0] class_label;
      logic                   trained;
   } rsp_payload_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]         kind;
      logic [FEATURE_WIDTH-1:0]      feature;
      logic signed [VALUE_WIDTH-1:0] threshold;
   } node_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_STEP,
      ST_LEAF
   } walk_state_type;

   function automatic logic kind_stops(input logic [KIND_WIDTH-1:0] kind);
      return (kind == KIND_UNUSED) || (kind == KIND_UNTRAINED);
   endfunction

endpackage

[rtl/decision_tree_classifier.sv]
`timescale 1ns / 1ps
// Flow: a load item is written to its table as it is popped from the command queue head.
// A classify steps through ROOT, STEP once per level down to the effective tree depth,
// and LEAF; a full result register stalls it; an unused or untrained node ends it early.
// Throughput: one item at a time in the walker; the queue and result register decouple it.
// Reset: synchronous; afterwards the node memory is cleared slot by slot in ST_CLEAR,
// while req_full stays high. Configuration writes are taken at any time.
module decision_tree_classifier #(
   parameter int MAX_DEPTH    = dtc_pkg::DEF_MAX_DEPTH,
   parameter int NUM_FEATURES = dtc_pkg::DEF_NUM_FEATURES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  dtc_pkg::req_payload_type        req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output dtc_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dtc_pkg::DEPTH_WIDTH-1:0] csr_data
);
   import dtc_pkg::*;

   logic [DEPTH_WIDTH-1:0] tree_depth_ff;
   logic                   engine_busy;
   logic                   queue_full, queue_push, queue_empty, queue_pop;
   req_payload_type        queue_in, queue_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_depth_ff <= TREE_DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         tree_depth_ff <= csr_data;
      end
   end

   dtc_front #(
      .MAX_DEPTH    (MAX_DEPTH),
      .NUM_FEATURES (NUM_FEATURES)
   ) u_front (
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .engine_busy (engine_busy),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_data  (queue_in)
   );

   dtc_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_data (queue_head),
      .empty     (queue_empty)
   );

   dtc_engine #(
      .MAX_DEPTH    (MAX_DEPTH),
      .NUM_FEATURES (NUM_FEATURES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .tree_depth (tree_depth_ff),
      .cmd_empty  (queue_empty),
      .cmd_data   (queue_head),
      .cmd_pop    (queue_pop),
      .busy       (engine_busy),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/dtc_front.sv]
`timescale 1ns / 1ps
module dtc_front #(
   parameter int MAX_DEPTH    = dtc_pkg::DEF_MAX_DEPTH,
   parameter int NUM_FEATURES = dtc_pkg::DEF_NUM_FEATURES
) (
   input  logic                     req_push,
   input  dtc_pkg::req_payload_type req_data,
   output logic                     req_full,
   input  logic                     engine_busy,
   input  logic                     queue_full,
   output logic                     queue_push,
   output dtc_pkg::req_payload_type queue_data
);
   import dtc_pkg::*;

   localparam int SLOTS = 1 << MAX_DEPTH;

   logic keep;

   assign req_full = queue_full || engine_busy;

   // Writes to slots beyond a table have no effect and never enter the queue.
   always_comb begin
      keep       = 1'b1;
      queue_data = req_data;
      case (req_data.op)
         OP_NODE,
         OP_LEAF: begin
            keep = (32'(req_data.slot_index) < 32'(SLOTS));
         end
         OP_FEATURE: begin
            keep = (32'(req_data.slot_index) < 32'(NUM_FEATURES));
         end
         default: begin
            keep = 1'b1;
         end
      endcase
      if (32'(req_data.leaf_label) > 32'(NUM_CLASSES - 1)) begin
         queue_data.leaf_label = LABEL_WIDTH'(NUM_CLASSES - 1);
      end
   end

   assign queue_push = req_push && !req_full && keep;

endmodule

[rtl/dtc_cmd_fifo.sv]
`timescale 1ns / 1ps
module dtc_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dtc_pkg::req_payload_type push_data,
   output logic                     full,
   input  logic                     pop,
   output dtc_pkg::req_payload_type head_data,
   output logic                     empty
);
   import dtc_pkg::*;

   localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

   req_payload_type entry_ff [CMD_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == (PW+1)'(CMD_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/dtc_engine.sv]
`timescale 1ns / 1ps
module dtc_engine #(
   parameter int MAX_DEPTH    = dtc_pkg::DEF_MAX_DEPTH,
   parameter int NUM_FEATURES = dtc_pkg::DEF_NUM_FEATURES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dtc_pkg::DEPTH_WIDTH-1:0]     tree_depth,
   input  logic                                cmd_empty,
   input  dtc_pkg::req_payload_type            cmd_data,
   output logic                                cmd_pop,
   output logic                                busy,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output dtc_pkg::rsp_payload_type            rsp_data
);
   import dtc_pkg::*;

   localparam int AW    = MAX_DEPTH;
   localparam int SLOTS = 1 << MAX_DEPTH;
   localparam int LW    = $clog2(MAX_DEPTH + 1);
   localparam int FAW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

   // Storage.
   node_entry_type                node_mem [SLOTS];
   logic [LABEL_WIDTH-1:0]        leaf_mem [SLOTS];
   logic signed [VALUE_WIDTH-1:0] feat_mem [NUM_FEATURES];

   node_entry_type                node_a_ff, node_b_ff;
   logic [LABEL_WIDTH-1:0]        leaf_ff;
   logic signed [VALUE_WIDTH-1:0] feat_ff;

   // Walk state.
   walk_state_type                state_ff, state_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic [LW-1:0]                 level_ff, level_in;
   logic [LW-1:0]                 depth_ff, depth_in;
   logic [AW-1:0]                 path_ff, path_in;
   logic signed [VALUE_WIDTH-1:0] thr_ff, thr_in;
   logic                          feat_ok_ff, feat_ok_in;
   logic                          rsp_valid_ff;
   rsp_payload_type               rsp_data_ff;

   // Memory controls.
   logic                          node_we;
   logic [AW-1:0]                 node_waddr;
   node_entry_type                node_wdata;
   logic                          node_re;
   logic [AW-1:0]                 node_raddr_a, node_raddr_b;
   logic                          leaf_we, leaf_re;
   logic [AW-1:0]                 leaf_waddr, leaf_raddr;
   logic                          feat_we, feat_re;
   logic [FAW-1:0]                feat_waddr, feat_raddr;
   logic [FEATURE_WIDTH-1:0]      feat_sel;
   logic                          rsp_load;
   rsp_payload_type               rsp_load_data;

   // Datapath helpers.
   logic                          out_free;
   logic [4:0]                    depth_req;
   logic [LW-1:0]                 depth_eff;
   logic signed [VALUE_WIDTH-1:0] x_value;
   logic                          go_right;
   logic [AW-1:0]                 new_path;
   logic [LW-1:0]                 new_level;
   logic [LW-1:0]                 child_level;
   node_entry_type                child;
   logic                          at_leaf;
   logic                          child_stops;
   logic [AW-1:0]                 descent_leaf;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign busy      = (state_ff == ST_CLEAR);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      depth_req = {1'b0, tree_depth};
      if (depth_req == 5'd0) begin
         depth_eff = LW'(1);
      end else if (depth_req > 5'(MAX_DEPTH)) begin
         depth_eff = LW'(MAX_DEPTH);
      end else begin
         depth_eff = LW'(depth_req);
      end
   end

   // One tree level per cycle: the children of the current node are read on
   // both node ports while its feature is read, and the compare picks one.
   assign x_value      = feat_ok_ff ? feat_ff : '0;
   assign go_right     = (thr_ff < x_value);
   assign new_path     = AW'({path_ff, go_right});
   assign new_level    = level_ff + LW'(1);
   assign child_level  = new_level + LW'(1);
   assign child        = go_right ? node_b_ff : node_a_ff;
   assign at_leaf      = (new_level == depth_ff);
   assign child_stops  = kind_stops(child.kind);
   assign descent_leaf = new_path << (depth_ff - new_level);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty && (cmd_data.op == OP_CLASSIFY)) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (kind_stops(node_a_ff.kind)) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (at_leaf || child_stops) begin
               state_in = ST_LEAF;
            end
         end
         ST_LEAF: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath register inputs.
   always_comb begin
      cmd_pop       = 1'b0;
      node_we       = 1'b0;
      node_waddr    = AW'(cmd_data.slot_index);
      node_wdata    = '{kind: cmd_data.node_kind, feature: cmd_data.split_feature,
                        threshold: cmd_data.value};
      node_re       = 1'b0;
      node_raddr_a  = AW'(1);
      node_raddr_b  = AW'(1);
      leaf_we       = 1'b0;
      leaf_waddr    = AW'(cmd_data.slot_index);
      leaf_re       = 1'b0;
      leaf_raddr    = new_path;
      feat_we       = 1'b0;
      feat_waddr    = FAW'(cmd_data.slot_index);
      feat_re       = 1'b0;
      feat_sel      = node_a_ff.feature;
      rsp_load      = 1'b0;
      rsp_load_data = '{class_label: leaf_ff, trained: 1'b1};
      clr_in        = clr_ff;
      level_in      = level_ff;
      depth_in      = depth_ff;
      path_in       = path_ff;
      thr_in        = thr_ff;
      case (state_ff)
         ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff;
            node_wdata = '0;
            clr_in     = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  OP_NODE: begin
                     node_we = 1'b1;
                  end
                  OP_LEAF: begin
                     leaf_we = 1'b1;
                  end
                  OP_FEATURE: begin
                     feat_we = 1'b1;
                  end
                  default: begin
                     node_re  = 1'b1;
                     level_in = '0;
                     path_in  = '0;
                     depth_in = depth_eff;
                  end
               endcase
            end
         end
         ST_ROOT: begin
            if (kind_stops(node_a_ff.kind)) begin
               rsp_load      = out_free;
               rsp_load_data = '{class_label: '0, trained: 1'b0};
            end else begin
               thr_in       = node_a_ff.threshold;
               feat_re      = 1'b1;
               feat_sel     = node_a_ff.feature;
               node_re      = 1'b1;
               node_raddr_a = AW'(2);
               node_raddr_b = AW'(3);
            end
         end
         ST_STEP: begin
            if (at_leaf) begin
               leaf_re    = 1'b1;
               leaf_raddr = new_path;
            end else if (child_stops) begin
               leaf_re    = 1'b1;
               leaf_raddr = descent_leaf;
            end else begin
               thr_in       = child.threshold;
               feat_re      = 1'b1;
               feat_sel     = child.feature;
               node_re      = 1'b1;
               node_raddr_a = (AW'(1) << child_level) | (new_path << 1);
               node_raddr_b = (AW'(1) << child_level) | (new_path << 1) | AW'(1);
               level_in     = new_level;
               path_in      = new_path;
            end
         end
         ST_LEAF: begin
            rsp_load = out_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign feat_raddr = FAW'(feat_sel);
   assign feat_ok_in = (32'(feat_sel) < 32'(NUM_FEATURES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      depth_ff <= depth_in;
      path_ff  <= path_in;
      thr_ff   <= thr_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_a_ff <= node_mem[node_raddr_a];
         node_b_ff <= node_mem[node_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_waddr] <= cmd_data.leaf_label;
      end
      if (leaf_re) begin
         leaf_ff <= leaf_mem[leaf_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[feat_waddr] <= cmd_data.value;
      end
      if (feat_re) begin
         feat_ff    <= feat_mem[feat_raddr];
         feat_ok_ff <= feat_ok_in;
      end
   end

endmodule

[tb/tb_decision_tree_classifier.sv]
`timescale 1ns / 1ps
module tb_decision_tree_classifier;
   import dtc_pkg::*;

   localparam logic [KIND_WIDTH-1:0] KIND_SPLIT = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE = 2'd3;
   localparam int NODE_SLOTS   = 1 << DEF_MAX_DEPTH;
   localparam int FEAT_AW      = $clog2(DEF_NUM_FEATURES);
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 42;
   localparam int SETTLE_LEN   = 40;
   localparam int HOLD_LEN     = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_PLAN [PHASES] =
      '{4'd1, 4'd10, 4'd0, 4'd15, 4'd5, 4'd7, 4'd2, 4'd10, 4'd6};

   typedef enum int {GAP_NONE, GAP_FEATURE, GAP_LEAF} gap_kind_type;

   // Holds a private copy of the tree and the queue of classify results still due.
   class tree_scoreboard;
      logic [DEPTH_WIDTH-1:0]        depth_reg;
      logic [KIND_WIDTH-1:0]         kind_mem [NODE_SLOTS];
      logic [FEATURE_WIDTH-1:0]      split_mem [NODE_SLOTS];
      logic signed [VALUE_WIDTH-1:0] thresh_mem [NODE_SLOTS];
      logic [LABEL_WIDTH-1:0]        label_mem [NODE_SLOTS];
      bit                            label_set [NODE_SLOTS];
      logic signed [VALUE_WIDTH-1:0] feature_mem [DEF_NUM_FEATURES];
      bit                            feature_set [DEF_NUM_FEATURES];
      rsp_payload_type               due_q [$];
      int                            results_seen;
      int                            untrained_seen;

      function new();
         depth_reg = TREE_DEPTH_RESET;
         foreach (kind_mem[i]) begin
            kind_mem[i] = KIND_UNUSED;
            split_mem[i] = '0;
            thresh_mem[i] = '0;
            label_mem[i] = '0;
            label_set[i] = 1'b0;
         end
         foreach (feature_mem[i]) begin
            feature_mem[i] = '0;
            feature_set[i] = 1'b0;
         end
         results_seen = 0;
         untrained_seen = 0;
      endfunction

      function int eff_depth();
         if (depth_reg == 0) return 1;
         if (depth_reg > DEF_MAX_DEPTH) return DEF_MAX_DEPTH;
         return int'(depth_reg);
      endfunction

      function bit stops(logic [KIND_WIDTH-1:0] k);
         return (k == KIND_UNUSED) || (k == KIND_UNTRAINED);
      endfunction

      // Walks the tree as the block would. Reports the first entry that the walk
      // would read before it was ever written, so the sender can fill it first.
      function gap_kind_type walk(output rsp_payload_type r, output int gap_idx);
         int leaf_base;
         int last;
         int node;
         int f;
         int leaf;
         r = '0;
         gap_idx = 0;
         leaf_base = 1 << eff_depth();
         last = leaf_base - 1;
         if (stops(kind_mem[1])) return GAP_NONE;
         node = 1;
         while (node <= last) begin
            f = int'(split_mem[node]);
            if (!feature_set[f]) begin
               gap_idx = f;
               return GAP_FEATURE;
            end
            node = 2 * node + ((thresh_mem[node] < feature_mem[f]) ? 1 : 0);
            if (node <= last && stops(kind_mem[node])) begin
               while (node <= last) node = node * 2;
               break;
            end
         end
         leaf = (node - leaf_base) & (NODE_SLOTS - 1);
         if (!label_set[leaf]) begin
            gap_idx = leaf;
            return GAP_LEAF;
         end
         r.class_label = label_mem[leaf];
         r.trained = 1'b1;
         return GAP_NONE;
      endfunction

      function void apply(req_payload_type q, output bit has_result,
                          output rsp_payload_type r);
         int gap_idx;
         has_result = 1'b0;
         r = '0;
         case (op_type'(q.op))
            OP_NODE: begin
               kind_mem[q.slot_index] = q.node_kind;
               split_mem[q.slot_index] = q.split_feature;
               thresh_mem[q.slot_index] = q.value;
            end
            OP_LEAF: begin
               label_mem[q.slot_index] = q.leaf_label;
               label_set[q.slot_index] = 1'b1;
            end
            OP_FEATURE: begin
               if (q.slot_index < DEF_NUM_FEATURES) begin
                  feature_mem[q.slot_index[FEAT_AW-1:0]] = q.value;
                  feature_set[q.slot_index[FEAT_AW-1:0]] = 1'b1;
               end
            end
            default: begin
               void'(walk(r, gap_idx));
               has_result = 1'b1;
            end
         endcase
      endfunction

      function void note_item(req_payload_type q);
         bit has_result;
         rsp_payload_type r;
         apply(q, has_result, r);
         if (has_result) due_q.insert(due_q.size(), r);
      endfunction

      function bit check_result(rsp_payload_type got);
         rsp_payload_type want;
         bit ok;
         ok = 1'b1;
         if (due_q.size() == 0) begin
            $display("%0t: result with nothing expected, got label %0d trained %0b",
                     $time, got.class_label, got.trained);
            return 1'b0;
         end
         want = due_q.pop_front();
         results_seen++;
         if (!want.trained) untrained_seen++;
         if (got.class_label !== want.class_label) begin
            $display("%0t: class_label mismatch, expected %0d, got %0d",
                     $time, want.class_label, got.class_label);
            ok = 1'b0;
         end
         if (got.trained !== want.trained) begin
            $display("%0t: trained mismatch, expected %0b, got %0b",
                     $time, want.trained, got.trained);
            ok = 1'b0;
         end
         return ok;
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   req_payload_type        req_data = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [DEPTH_WIDTH-1:0] csr_data = '0;

   tree_scoreboard sb;
   tree_scoreboard plan;  // tracks the tree as items are offered, to keep reads defined
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int hold_token = 0;
   int failures = 0;
   int items_taken = 0;
   int cycles = 0;

   decision_tree_classifier dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_push && !req_full) begin
         sb.note_item(req_data);
         items_taken++;
      end
   end

   // Result side: takes results, and holds off for a long stretch on request.
   int hold_seen = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (rsp_pop && !rsp_empty) begin
         if (!sb.check_result(rsp_data)) failures++;
      end
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_LEN;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("[decision_tree_classifier] ERROR");
      $finish;
   end

   function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1: return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type rand_payload();
      req_payload_type q;
      q.op = 2'($urandom_range(0, 3));
      q.slot_index = SLOT_WIDTH'($urandom_range(0, NODE_SLOTS - 1));
      q.node_kind = KIND_WIDTH'($urandom_range(0, 3));
      q.split_feature = FEATURE_WIDTH'($urandom_range(0, DEF_NUM_FEATURES - 1));
      q.value = $urandom;
      q.leaf_label = LABEL_WIDTH'($urandom_range(0, NUM_CLASSES - 1));
      return q;
   endfunction

   task automatic send_item(req_payload_type q);
      bit has_result;
      rsp_payload_type r;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      plan.apply(q, has_result, r);
      req_push <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_node(int slot, logic [KIND_WIDTH-1:0] k, int f,
                            logic signed [VALUE_WIDTH-1:0] v);
      req_payload_type q;
      q = rand_payload();
      q.op = OP_NODE;
      q.slot_index = SLOT_WIDTH'(slot);
      q.node_kind = k;
      q.split_feature = FEATURE_WIDTH'(f);
      q.value = v;
      send_item(q);
   endtask

   task automatic send_leaf(int slot, logic [LABEL_WIDTH-1:0] lab);
      req_payload_type q;
      q = rand_payload();
      q.op = OP_LEAF;
      q.slot_index = SLOT_WIDTH'(slot);
      q.leaf_label = lab;
      send_item(q);
   endtask

   task automatic send_feature(int slot, logic signed [VALUE_WIDTH-1:0] v);
      req_payload_type q;
      q = rand_payload();
      q.op = OP_FEATURE;
      q.slot_index = SLOT_WIDTH'(slot);
      q.value = v;
      send_item(q);
   endtask

   // Any feature or leaf label that this classify would read unwritten is loaded first.
   task automatic send_classify();
      req_payload_type q;
      rsp_payload_type r;
      gap_kind_type gap;
      int gap_idx;
      gap = plan.walk(r, gap_idx);
      while (gap != GAP_NONE) begin
         if (gap == GAP_FEATURE) send_feature(gap_idx, rand_value());
         else send_leaf(gap_idx, LABEL_WIDTH'($urandom_range(0, NUM_CLASSES - 1)));
         gap = plan.walk(r, gap_idx);
      end
      q = rand_payload();
      q.op = OP_CLASSIFY;
      send_item(q);
   endtask

   task automatic random_item();
      int d;
      int pick;
      int node;
      logic [KIND_WIDTH-1:0] k;
      req_payload_type q;
      d = plan.eff_depth();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         send_classify();
      end else if (pick < 60) begin
         // A random path down from the root, so splits chain into deep walks.
         node = 1;
         repeat ($urandom_range(0, d - 1)) node = 2 * node + $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            0: k = KIND_UNUSED;
            1: k = KIND_UNTRAINED;
            2: k = KIND_SPARE;
            default: k = KIND_SPLIT;
         endcase
         send_node(node, k, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                   : $urandom_range(0, DEF_NUM_FEATURES - 1), rand_value());
      end else if (pick < 75) begin
         send_leaf($urandom_range(0, (1 << d) - 1),
                   LABEL_WIDTH'($urandom_range(0, NUM_CLASSES - 1)));
      end else if (pick < 90) begin
         send_feature(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                      : $urandom_range(0, DEF_NUM_FEATURES - 1), rand_value());
      end else begin
         q = rand_payload();
         if (op_type'(q.op) == OP_CLASSIFY) send_classify();
         else send_item(q);
      end
   endtask

   task automatic write_depth(logic [DEPTH_WIDTH-1:0] d);
      csr_valid <= 1'b1;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.depth_reg = d;
      plan.depth_reg = d;
   endtask

   // Stops offering items and waits until every classify has answered.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   initial begin
      sb = new();
      plan = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 33;
      recv_gap_pct = 73;
      write_depth(4'd3);

      send_classify();
      send_feature(0, 32'sh7fff_ffff);
      send_feature(1, 32'sh8000_0000);
      send_feature(2, 32'sh0);
      send_feature(63, -32'sd1);
      send_feature(1023, 32'sh1234_5678);
      send_node(1, KIND_UNTRAINED, 0, 32'sh0);
      send_classify();
      // Threshold equal to the feature goes left; node 2 unused falls to leaf 0.
      send_node(1, KIND_SPLIT, 0, 32'sh7fff_ffff);
      send_classify();
      send_node(2, KIND_SPLIT, 1, 32'sh8000_0000);
      send_node(4, KIND_SPARE, 63, 32'sh8000_0000);
      send_classify();
      send_node(1, KIND_SPLIT, 2, 32'sh8000_0000);
      send_node(3, KIND_UNTRAINED, 0, 32'sh0);
      send_classify();
      send_node(0, KIND_SPLIT, 63, -32'sd1);
      send_leaf(7, 8'd255);
      send_leaf(6, 8'd0);
      send_node(3, KIND_SPLIT, 63, -32'sd2);
      send_classify();
      send_node(7, KIND_SPLIT, 0, 32'sh7fff_fffe);
      send_classify();
      settle();

      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin
               send_gap_pct = 33;
               recv_gap_pct = 73;
            end
            1: begin
               send_gap_pct = 73;
               recv_gap_pct = 33;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase
         write_depth(DEPTH_PLAN[p]);
         if (p == 1 || p == PHASES - 3) hold_token++;
         repeat (PHASE_ITEMS) random_item();
         settle();
      end

      if (sb.pending() > 0) begin
         $display("%0t: %0d results never arrived", $time, sb.pending());
         failures++;
      end
      $display("Covered %0d items and %0d classify results, %0d with an untrained root,",
               items_taken, sb.results_seen, sb.untrained_seen);
      $display("across %0d depth settings with sender and receiver gaps and a long stall.",
               PHASES + 1);
      if (failures == 0) begin
         $display("[decision_tree_classifier] OK");
      end else begin
         $display("[decision_tree_classifier] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/dtc_pkg.sv
rtl/dtc_front.sv
rtl/dtc_cmd_fifo.sv
rtl/dtc_engine.sv
rtl/decision_tree_classifier.sv
tb/tb_decision_tree_classifier.sv
